>>> hdl/afrd_pkg.sv
// shared types and constants of the api frame receive deframer
`default_nettype none

package afrd_pkg;

    localparam int FRAME_BYTES_DEF   = 128;
    localparam int PAYLOAD_BYTES_DEF = 64;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 16;
    localparam int POS_W   = 7;
    localparam int GW_W    = 64;
    localparam int GW_BYTES = 8;
    localparam int GWCNT_W = 4;
    localparam int TDATA_W = 72;
    localparam int TUSER_W = 4;

    localparam logic [BYTE_W-1:0] START_BYTE      = 8'h7E;
    localparam logic [BYTE_W-1:0] TYPE_STATUS     = 8'd139;
    localparam logic [BYTE_W-1:0] TYPE_ROUTE      = 8'd161;
    localparam logic [BYTE_W-1:0] DATA_TYPE_RESET = 8'd144;
    localparam logic [BYTE_W-1:0] SUM_GOOD        = 8'hFF;
    localparam logic [POS_W-1:0]  PAYLOAD_POS     = 7'd12;

    typedef enum logic [2:0] {
        VERDICT_BAD_START = 3'd0,
        VERDICT_ACCEPTED  = 3'd1,
        VERDICT_CHECKSUM  = 3'd2,
        VERDICT_STATUS    = 3'd3,
        VERDICT_OTHER     = 3'd4,
        VERDICT_TOO_LONG  = 3'd5
    } verdict_t;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_LEN_HI = 2'd1,
        PH_LEN_LO = 2'd2,
        PH_DATA   = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        SEQ_IDLE     = 3'd0,
        SEQ_GW_RD    = 3'd1,
        SEQ_GW_WAIT  = 3'd2,
        SEQ_LEN_RD   = 3'd3,
        SEQ_LEN_WAIT = 3'd4,
        SEQ_PL_RD    = 3'd5,
        SEQ_PL_WAIT  = 3'd6
    } seq_t;

endpackage

`default_nettype wire

>>> hdl/api_frame_receive_deframer_top.sv
// top level of the api frame receive deframer
//
// s_axis carries received serial bytes, one per request, in tdata[7:0].
// frames are 0x7e, length high, length low, frame data, checksum. every
// request that ends a frame or breaks the start hunt gives results on m_axis;
// length and data bytes give none. an accepted data frame gives one result per
// payload byte (up to PAYLOAD_BYTES), the last one with tlast; every other
// outcome gives a single result with tlast.
// bytes are taken one per cycle while a frame streams in. after an accepted
// checksum byte the sequencer works from the frame store through the single
// read port, a read state and a wait state per read: eight reads latch the
// gateway address if its top half is zero, one the payload length, one per byte.
// input is blocked during that replay. the result register lets a new byte in
// while a result waits, except for bytes that may themselves give a result.
// a stalled receiver holds the result register and the sequencer's result waits.
// cfg_wr_en writes the data frame type; write only while the block is idle.
// reset returns to start hunting, clears the gateway address and sets the data
// frame type to 144. the frame store needs no clearing: only bytes of the
// current frame are read.
`default_nettype none

module api_frame_receive_deframer_top #(
    parameter int FRAME_BYTES   = afrd_pkg::FRAME_BYTES_DEF,
    parameter int PAYLOAD_BYTES = afrd_pkg::PAYLOAD_BYTES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [afrd_pkg::BYTE_W-1:0]  cfg_wr_data,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [afrd_pkg::BYTE_W-1:0]  s_axis_tdata,   // rx_byte
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [afrd_pkg::TDATA_W-1:0]      m_axis_tdata,   // payload_byte, gateway_address
    output logic [afrd_pkg::TUSER_W-1:0]      m_axis_tuser,   // verdict, byte_valid
    output logic                              m_axis_tlast
);

    import afrd_pkg::*;

    localparam int ADDR_W = $clog2(FRAME_BYTES);
    localparam int CNT_W  = $clog2(PAYLOAD_BYTES + 1);

    logic [BYTE_W-1:0] dtype_reg;

    phase_t            phase_reg, phase_next;
    seq_t              seq_reg, seq_next;
    logic [LEN_W-1:0]  flen_reg, flen_next;
    logic [LEN_W-1:0]  bcount_reg, bcount_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [BYTE_W-1:0] ftype_reg, ftype_next;
    logic [GW_W-1:0]   gw_reg, gw_next;
    logic [GWCNT_W-1:0] gwcnt_reg, gwcnt_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic              rd_ok_reg, rd_ok_next;

    logic              out_valid_reg, out_valid_next;
    verdict_t          out_verdict_reg, out_verdict_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_bvalid_reg, out_bvalid_next;
    logic              out_last_reg, out_last_next;

    logic              in_fire;
    logic              out_free;
    logic              frame_end;
    logic [BYTE_W-1:0] sum_add;
    logic [BYTE_W-1:0] frame_type;
    logic              too_long;
    verdict_t          verdict;
    logic [POS_W-1:0]  rd_pos;
    logic              rd_en;
    logic              ram_we;
    logic [BYTE_W-1:0] ram_rdata;
    logic [BYTE_W-1:0] rd_byte;
    logic [CNT_W-1:0]  n_cap;
    logic              pl_last;

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign frame_end = (phase_reg == PH_DATA) && !(bcount_reg < flen_reg);
    assign sum_add   = sum_reg + s_axis_tdata;
    assign frame_type = (flen_reg == '0) ? '0 : ftype_reg;
    assign too_long  = {1'b0, flen_reg} >= (LEN_W + 1)'(FRAME_BYTES);

    always_comb
    begin
        if (sum_add != SUM_GOOD)
        begin
            verdict = VERDICT_CHECKSUM;
        end
        else if (too_long)
        begin
            verdict = VERDICT_TOO_LONG;
        end
        else if (frame_type == TYPE_STATUS || frame_type == TYPE_ROUTE)
        begin
            verdict = VERDICT_STATUS;
        end
        else if (frame_type == dtype_reg)
        begin
            verdict = VERDICT_ACCEPTED;
        end
        else
        begin
            verdict = VERDICT_OTHER;
        end
    end

    // store reads: zero past the end of the frame data
    assign rd_byte = rd_ok_reg ? ram_rdata : '0;
    assign n_cap   = (rd_byte > BYTE_W'(PAYLOAD_BYTES)) ? CNT_W'(PAYLOAD_BYTES)
                                                        : CNT_W'(rd_byte);
    assign pl_last = (idx_reg + CNT_W'(1)) == n_reg;

    always_comb
    begin
        unique case (seq_reg)
            SEQ_GW_RD:
            begin
                rd_en  = 1'b1;
                rd_pos = POS_W'(gwcnt_reg);
            end
            SEQ_LEN_RD:
            begin
                rd_en  = 1'b1;
                rd_pos = PAYLOAD_POS;
            end
            SEQ_PL_RD:
            begin
                rd_en  = 1'b1;
                rd_pos = PAYLOAD_POS + POS_W'(idx_reg);
            end
            default:
            begin
                rd_en  = 1'b0;
                rd_pos = '0;
            end
        endcase
    end

    assign rd_ok_next = rd_en ? (LEN_W'(rd_pos) < flen_reg) : rd_ok_reg;

    assign ram_we = in_fire && (phase_reg == PH_DATA) && (bcount_reg < flen_reg)
                    && ({1'b0, bcount_reg} < (LEN_W + 1)'(FRAME_BYTES));

    afrd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FRAME_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ADDR_W'(bcount_reg)),
        .wdata (s_axis_tdata),
        .re    (rd_en),
        .raddr (ADDR_W'(rd_pos)),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        s_axis_tready = 1'b0;
        if (seq_reg == SEQ_IDLE)
        begin
            if (phase_reg == PH_LEN_HI || phase_reg == PH_LEN_LO)
            begin
                s_axis_tready = 1'b1;
            end
            else if (phase_reg == PH_DATA && !frame_end)
            begin
                s_axis_tready = 1'b1;
            end
            else
            begin
                s_axis_tready = out_free;
            end
        end
    end

    // sequencer next state
    always_comb
    begin
        seq_next = seq_reg;
        unique case (seq_reg)
            SEQ_IDLE:
            begin
                if (in_fire && frame_end && verdict == VERDICT_ACCEPTED)
                begin
                    seq_next = (gw_reg[GW_W-1:GW_W/2] == '0) ? SEQ_GW_RD : SEQ_LEN_RD;
                end
            end
            SEQ_GW_RD:
            begin
                seq_next = SEQ_GW_WAIT;
            end
            SEQ_GW_WAIT:
            begin
                seq_next = (gwcnt_reg == GWCNT_W'(GW_BYTES)) ? SEQ_LEN_RD : SEQ_GW_RD;
            end
            SEQ_LEN_RD:
            begin
                seq_next = SEQ_LEN_WAIT;
            end
            SEQ_LEN_WAIT:
            begin
                if (n_cap != '0)
                begin
                    seq_next = SEQ_PL_RD;
                end
                else if (out_free)
                begin
                    seq_next = SEQ_IDLE;
                end
            end
            SEQ_PL_RD:
            begin
                seq_next = SEQ_PL_WAIT;
            end
            SEQ_PL_WAIT:
            begin
                if (out_free)
                begin
                    seq_next = pl_last ? SEQ_IDLE : SEQ_PL_RD;
                end
            end
            default:
            begin
                seq_next = SEQ_IDLE;
            end
        endcase
    end

    // parser and result datapath
    always_comb
    begin
        phase_next       = phase_reg;
        flen_next        = flen_reg;
        bcount_next      = bcount_reg;
        sum_next         = sum_reg;
        ftype_next       = ftype_reg;
        gw_next          = gw_reg;
        gwcnt_next       = gwcnt_reg;
        idx_next         = idx_reg;
        n_next           = n_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_verdict_next = out_verdict_reg;
        out_byte_next    = out_byte_reg;
        out_bvalid_next  = out_bvalid_reg;
        out_last_next    = out_last_reg;

        unique case (seq_reg)
            SEQ_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (phase_reg)
                        PH_HUNT:
                        begin
                            if (s_axis_tdata == START_BYTE)
                            begin
                                phase_next = PH_LEN_HI;
                            end
                            else
                            begin
                                out_valid_next   = 1'b1;
                                out_verdict_next = VERDICT_BAD_START;
                                out_byte_next    = '0;
                                out_bvalid_next  = 1'b0;
                                out_last_next    = 1'b1;
                            end
                        end
                        PH_LEN_HI:
                        begin
                            flen_next  = {s_axis_tdata, flen_reg[BYTE_W-1:0]};
                            phase_next = PH_LEN_LO;
                        end
                        PH_LEN_LO:
                        begin
                            flen_next   = {flen_reg[LEN_W-1:BYTE_W], s_axis_tdata};
                            bcount_next = '0;
                            sum_next    = '0;
                            phase_next  = PH_DATA;
                        end
                        PH_DATA:
                        begin
                            if (!frame_end)
                            begin
                                sum_next    = sum_add;
                                bcount_next = bcount_reg + LEN_W'(1);
                                if (bcount_reg == '0)
                                begin
                                    ftype_next = s_axis_tdata;
                                end
                            end
                            else
                            begin
                                phase_next  = PH_HUNT;
                                bcount_next = '0;
                                sum_next    = '0;
                                gwcnt_next  = GWCNT_W'(1);
                                if (verdict != VERDICT_ACCEPTED)
                                begin
                                    out_valid_next   = 1'b1;
                                    out_verdict_next = verdict;
                                    out_byte_next    = '0;
                                    out_bvalid_next  = 1'b0;
                                    out_last_next    = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = PH_HUNT;
                        end
                    endcase
                end
            end
            SEQ_GW_WAIT:
            begin
                gw_next    = {gw_reg[GW_W-BYTE_W-1:0], rd_byte};
                gwcnt_next = gwcnt_reg + GWCNT_W'(1);
            end
            SEQ_LEN_WAIT:
            begin
                n_next   = n_cap;
                idx_next = '0;
                if (n_cap == '0 && out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_verdict_next = VERDICT_ACCEPTED;
                    out_byte_next    = '0;
                    out_bvalid_next  = 1'b0;
                    out_last_next    = 1'b1;
                end
            end
            SEQ_PL_WAIT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_verdict_next = VERDICT_ACCEPTED;
                    out_byte_next    = rd_byte;
                    out_bvalid_next  = 1'b1;
                    out_last_next    = pl_last;
                    idx_next         = idx_reg + CNT_W'(1);
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dtype_reg     <= DATA_TYPE_RESET;
            phase_reg     <= PH_HUNT;
            seq_reg       <= SEQ_IDLE;
            flen_reg      <= '0;
            bcount_reg    <= '0;
            sum_reg       <= '0;
            gw_reg        <= '0;
            gwcnt_reg     <= '0;
            idx_reg       <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                dtype_reg <= cfg_wr_data;
            end
            phase_reg     <= phase_next;
            seq_reg       <= seq_next;
            flen_reg      <= flen_next;
            bcount_reg    <= bcount_next;
            sum_reg       <= sum_next;
            gw_reg        <= gw_next;
            gwcnt_reg     <= gwcnt_next;
            idx_reg       <= idx_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ftype_reg       <= ftype_next;
        rd_ok_reg       <= rd_ok_next;
        out_verdict_reg <= out_verdict_next;
        out_byte_reg    <= out_byte_next;
        out_bvalid_reg  <= out_bvalid_next;
        out_last_reg    <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {gw_reg, out_byte_reg};
    assign m_axis_tuser  = {out_bvalid_reg, out_verdict_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

>>> hdl/afrd_ram.sv
// generic single-port-write ram with registered read
`default_nettype none

module afrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
